// ===== rtl/lmc_pkg.sv =====
// ---------------------------------------------------------------------------
// lmc_pkg: shared types and constants of the LED matrix cascade core
// Operation codes, write-data sources and the controller/datapath
// command and status bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package lmc_pkg;

    // Fixed field widths
    localparam int OP_W      = 3;
    localparam int COL_W     = 5;   // column address, covers the largest chain
    localparam int BYTE_W    = 8;
    localparam int CADDR_W   = 4;
    localparam int WORD_W    = 16;
    localparam int DEV_W     = 2;   // device index, up to four devices
    localparam int SUB_W     = 3;   // column or row within one device
    localparam int MAX_DEV   = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_BCAST = 3'd4;

    // Write-data sources
    localparam logic [1:0] SRC_INPUT = 2'd0;
    localparam logic [1:0] SRC_ZERO  = 2'd1;
    localparam logic [1:0] SRC_RDATA = 2'd2;

    typedef struct packed {
        logic             latch;      // capture the accepted item's fields
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             rd_cap;     // shift the read column into the transposer
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
        logic [1:0]       wr_src;
        logic             emit_frame;
        logic             emit_bcast;
        logic [SUB_W-1:0] row;
        logic [DEV_W-1:0] dev;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic out_free;               // output register can take a beat
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/lmc_ram.sv =====
// ---------------------------------------------------------------------------
// lmc_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module lmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lmc_dp.sv =====
// ---------------------------------------------------------------------------
// lmc_dp: datapath of the LED matrix cascade core
// Column store, 8x8 transposer and the registered output frame.
// ---------------------------------------------------------------------------
`default_nettype none

module lmc_dp #(
    parameter int DEVICES = 4
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire lmc_pkg::t_cmd                    i_cmd,
    output lmc_pkg::t_sts                         o_sts,
    input  wire logic [lmc_pkg::BYTE_W-1:0]       i_value_byte,
    input  wire logic [lmc_pkg::CADDR_W-1:0]      i_command_address,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic      [lmc_pkg::WORD_W-1:0]       o_word_first,
    output logic      [lmc_pkg::WORD_W-1:0]       o_word_second,
    output logic      [lmc_pkg::WORD_W-1:0]       o_word_third,
    output logic      [lmc_pkg::WORD_W-1:0]       o_word_fourth,
    output logic                                  o_last_of_run
);
    import lmc_pkg::*;

    localparam int NCOLS = DEVICES * 8;
    localparam int AW    = $clog2(NCOLS);

    logic [BYTE_W-1:0]  r_val;
    logic [CADDR_W-1:0] r_caddr;
    logic [BYTE_W-1:0]  r_rows [8];
    logic               r_cap;
    logic [BYTE_W-1:0]  rd_data;
    logic [BYTE_W-1:0]  wr_data;
    logic [WORD_W-1:0]  r_word [MAX_DEV];
    logic               r_valid;
    logic               r_last;
    logic [WORD_W-1:0]  frame_word;
    logic [WORD_W-1:0]  bcast_word;
    logic [SUB_W:0]     row_num;

    always_comb begin
        unique case (i_cmd.wr_src)
            SRC_INPUT: wr_data = i_value_byte;
            SRC_RDATA: wr_data = rd_data;
            default:   wr_data = '0;
        endcase
    end

    lmc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (NCOLS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_cmd.wr_addr[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_cmd.rd_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_val   <= i_value_byte;
            r_caddr <= i_command_address;
        end
    end

    // Column c arrives in order 0..7; bit r of it lands in row r, MSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 1'b0;
        end else begin
            r_cap <= i_cmd.rd_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cap) begin
            for (int r = 0; r < 8; r++) begin
                r_rows[r] <= {r_rows[r][BYTE_W-2:0], rd_data[r]};
            end
        end
    end

    assign row_num    = {1'b0, i_cmd.row} + 4'd1;
    assign frame_word = {4'b0000, row_num, r_rows[i_cmd.row]};
    assign bcast_word = {4'b0000, r_caddr, r_val};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit_frame || i_cmd.emit_bcast) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_frame) begin
            for (int k = 0; k < MAX_DEV; k++) begin
                r_word[k] <= (DEV_W'(k) == i_cmd.dev) ? frame_word : '0;
            end
            r_last <= i_cmd.last;
        end else if (i_cmd.emit_bcast) begin
            for (int k = 0; k < MAX_DEV; k++) begin
                r_word[k] <= (k < DEVICES) ? bcast_word : '0;
            end
            r_last <= 1'b1;
        end
    end

    assign o_sts.out_free = !r_valid || i_out_ready;
    assign o_out_valid    = r_valid;
    assign o_word_first   = r_word[0];
    assign o_word_second  = r_word[1];
    assign o_word_third   = r_word[2];
    assign o_word_fourth  = r_word[3];
    assign o_last_of_run  = r_last;

endmodule

`default_nettype wire

// ===== rtl/lmc_ctrl.sv =====
// ---------------------------------------------------------------------------
// lmc_ctrl: sequencer of the LED matrix cascade core
// Decodes operations and walks the column store for clear, shift and flush.
// ---------------------------------------------------------------------------
`default_nettype none

module lmc_ctrl #(
    parameter int DEVICES = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [lmc_pkg::OP_W-1:0]      i_operation,
    input  wire logic [lmc_pkg::COL_W-1:0]     i_column_index,
    output lmc_pkg::t_cmd                      o_cmd,
    input  wire lmc_pkg::t_sts                 i_sts
);
    import lmc_pkg::*;

    localparam int NCOLS = DEVICES * 8;
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(NCOLS - 1);
    localparam logic [COL_W-1:0] SHIFT_TOP = COL_W'(NCOLS - 2);
    localparam logic [DEV_W-1:0] LAST_DEV  = DEV_W'(DEVICES - 1);
    localparam logic [SUB_W-1:0] LAST_SUB  = 3'd7;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_EMIT  = 4'd4;
    localparam logic [3:0] S_SHIFT = 4'd5;
    localparam logic [3:0] S_SHEND = 4'd6;
    localparam logic [3:0] S_ZERO  = 4'd7;
    localparam logic [3:0] S_BCAST = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [COL_W-1:0] r_col, n_col;
    logic [SUB_W-1:0] r_sub, n_sub;
    logic [DEV_W-1:0] r_dev, n_dev;
    logic             r_init, n_init;
    logic             r_push1, n_push1;
    logic             r_wb, n_wb;
    logic [COL_W-1:0] r_wba, n_wba;
    logic             accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_sub   = r_sub;
        n_dev   = r_dev;
        n_init  = r_init;
        n_push1 = r_push1;
        n_wb    = 1'b0;
        n_wba   = r_wba;

        o_cmd            = '0;
        o_cmd.latch      = accept;
        o_cmd.rd_addr    = {r_dev, r_sub};
        o_cmd.row        = r_sub;
        o_cmd.dev        = r_dev;
        o_cmd.last       = !r_push1 && (r_dev == LAST_DEV) && (r_sub == LAST_SUB);
        // pending write-back of a shifted column
        o_cmd.wr_en      = r_wb;
        o_cmd.wr_addr    = r_wba;
        o_cmd.wr_src     = SRC_RDATA;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_dev = '0;
                    n_sub = '0;
                    unique case (i_operation)
                        OP_PUSH: begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_addr = '0;
                            o_cmd.wr_src  = SRC_INPUT;
                            n_push1       = 1'b1;
                            n_state       = S_LOAD;
                        end
                        OP_WRITE: begin
                            o_cmd.wr_en   = ({1'b0, i_column_index} < (COL_W+1)'(NCOLS));
                            o_cmd.wr_addr = i_column_index;
                            o_cmd.wr_src  = SRC_INPUT;
                        end
                        OP_FLUSH: begin
                            n_push1 = 1'b0;
                            n_state = S_LOAD;
                        end
                        OP_CLEAR: begin
                            n_col   = '0;
                            n_init  = 1'b0;
                            n_state = S_CLR;
                        end
                        OP_BCAST: begin
                            n_state = S_BCAST;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_col;
                o_cmd.wr_src  = SRC_ZERO;
                if (r_col == LAST_COL) begin
                    n_dev   = '0;
                    n_sub   = '0;
                    n_push1 = 1'b0;
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_LOAD;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            S_LOAD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_cap = 1'b1;
                n_sub        = r_sub + 1'b1;
                if (r_sub == LAST_SUB) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_frame = 1'b1;
                    n_sub            = r_sub + 1'b1;
                    if (r_sub == LAST_SUB) begin
                        if (r_dev != LAST_DEV) begin
                            n_dev   = r_dev + 1'b1;
                            n_state = S_LOAD;
                        end else if (r_push1) begin
                            n_col   = SHIFT_TOP;
                            n_state = S_SHIFT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_col;
                n_wb          = 1'b1;
                n_wba         = r_col + 1'b1;
                if (r_col == '0) begin
                    n_state = S_SHEND;
                end else begin
                    n_col = r_col - 1'b1;
                end
            end
            S_SHEND: begin
                n_state = S_ZERO;
            end
            S_ZERO: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = '0;
                o_cmd.wr_src  = SRC_ZERO;
                n_push1       = 1'b0;
                n_dev         = '0;
                n_sub         = '0;
                n_state       = S_LOAD;
            end
            S_BCAST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_bcast = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_col   <= '0;
            r_sub   <= '0;
            r_dev   <= '0;
            r_init  <= 1'b1;
            r_push1 <= 1'b0;
            r_wb    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_sub   <= n_sub;
            r_dev   <= n_dev;
            r_init  <= n_init;
            r_push1 <= n_push1;
            r_wb    <= n_wb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wba <= n_wba;
    end

endmodule

`default_nettype wire

// ===== rtl/led_matrix_cascade_framebuffer_core.sv =====
// ---------------------------------------------------------------------------
// led_matrix_cascade_framebuffer_core: column framebuffer for chained 8x8
// LED matrix drivers
// Keeps one pixel byte per display column, transposes each device's columns
// into row bytes on a flush and emits one frame of four words per row.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   in      | sink      | i_in_valid/o_in_ready  | operation, column_index,
//           |           |                        | value_byte, command_address
//   out     | source    | o_out_valid/i_out_ready| word_first..fourth, last_of_run
//
// Sequence: a flush walks the store one column per cycle through the single
//   read port: for each device it reads 8 columns, waits for the registered
//   read data and emits 8 frames, each as the output register is free. A push
//   costs two flushes plus a shift of every column up by one (the last
//   write-back included) and one zero write; a clear costs a zeroing pass
//   plus a flush; a write column is stored on acceptance; a broadcast emits one frame.
// Reset: a clearing pass zeroes every column of the store; no item is
//   taken until it ends.
// Stalls: the output register holds a frame until taken; the sequencer
//   waits while it is full and not drained.
// ---------------------------------------------------------------------------
`default_nettype none

module led_matrix_cascade_framebuffer_core #(
    parameter int DEVICES = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [lmc_pkg::OP_W-1:0]      i_operation,
    input  wire logic [lmc_pkg::COL_W-1:0]     i_column_index,
    input  wire logic [lmc_pkg::BYTE_W-1:0]    i_value_byte,
    input  wire logic [lmc_pkg::CADDR_W-1:0]   i_command_address,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [lmc_pkg::WORD_W-1:0]    o_word_first,
    output logic      [lmc_pkg::WORD_W-1:0]    o_word_second,
    output logic      [lmc_pkg::WORD_W-1:0]    o_word_third,
    output logic      [lmc_pkg::WORD_W-1:0]    o_word_fourth,
    output logic                               o_last_of_run
);
    import lmc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer: decode each beat, drive the store walk and frame emission
    lmc_ctrl #(
        .DEVICES (DEVICES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_column_index (i_column_index),
        .o_cmd          (cmd),
        .i_sts          (sts)
    );

    // Datapath: column store, transposer, output frame register
    lmc_dp #(
        .DEVICES (DEVICES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_value_byte      (i_value_byte),
        .i_command_address (i_command_address),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_word_first      (o_word_first),
        .o_word_second     (o_word_second),
        .o_word_third      (o_word_third),
        .o_word_fourth     (o_word_fourth),
        .o_last_of_run     (o_last_of_run)
    );

`ifndef SYNTHESIS
    // Never load a frame over one that is still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_frame || cmd.emit_bcast) |-> sts.out_free)
        else $error("frame emitted into a full output register");

    // Shift write-back must never hit the address being read
    a_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.wr_en && cmd.rd_en) |-> (cmd.wr_addr != cmd.rd_addr))
        else $error("store read and write at the same address");

    // A flush or broadcast beat keeps the input side closed the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_operation == OP_BCAST || i_operation == OP_FLUSH))
        |=> !o_in_ready)
        else $error("input taken while a run is in progress");
`endif

endmodule

`default_nettype wire
